[sv/ist_pkg.sv]
// Shared constants for the integer set table: store depth, derived widths,
// operation codes and stream field widths.
// No dependencies.
`default_nettype none

package ist_pkg;

  // Store depth and the widths that follow from it
  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Stream field widths
  localparam int FUNC_W     = 3;
  localparam int VAL_W      = 32;
  localparam int CNT_F_W    = 5;
  localparam int OUT_DATA_W = 40;

  // Operation codes
  localparam logic [FUNC_W-1:0] FN_INSERT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_DELETE = 3'd1;
  localparam logic [FUNC_W-1:0] FN_LOOKUP = 3'd2;
  localparam logic [FUNC_W-1:0] FN_LIST   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd4;

endpackage

`default_nettype wire

[sv/ist_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while no read is requested.
// No dependencies.
`default_nettype none

module ist_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  wire logic                                  clk,
  input  wire logic                                  wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                      wr_data,
  input  wire logic                                  rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[sv/integer_set_table_unit.sv]
// Top level of the integer set table: sequencer around a one-port-read,
// one-port-write RAM holding the packed set, plus the output register.
// Depends on ist_pkg and ist_ram.
//
//   channel | dir | tdata                         | tuser          | tlast
//   --------+-----+-------------------------------+----------------+------
//   in_     | in  | value[31:0]                   | func[2:0]      | -
//   out_    | out | found, refused_full, count,   | element_valid  | last
//           |     | element (from bit 0 up)       |                |
//
// Insert and lookup scan the stored entries through the RAM read port,
// one entry per cycle, and stop early on a hit; the next request is
// taken in the cycle after the result is loaded. Delete adds a shift pass
// over the entries above the hit, one per cycle. List reads newest first,
// one element per cycle while the output is taken.
// Reset clears the state, the element count and the output valid; RAM contents are never cleared.
// A stalled output holds the sequencer at its next result; a new request
// is taken whenever the sequencer is idle, even with a result waiting.
`default_nettype none

module integer_set_table_unit
  import ist_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // request stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [VAL_W-1:0]      in_tdata,   // [31:0] value
  input  wire logic [FUNC_W-1:0]     in_tuser,   // [2:0] func
  // result stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // [0] found, [1] refused_full,
                                                 // [6:2] count, [38:7] element,
                                                 // [39] zero
  output logic                       out_tuser,  // [0] element_valid
  output logic                       out_tlast
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_LIST,
    S_EMIT
  } state_t;

  state_t                state_r;
  logic [FUNC_W-1:0]     func_r;
  logic [VAL_W-1:0]      value_r;
  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      addr_r;
  logic                  chk_valid_r;
  logic [IDX_W-1:0]      chk_idx_r;
  logic                  lst_more_r;
  logic                  res_found_r;
  logic                  res_refused_r;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_user_r;
  logic                  out_last_r;

  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic [VAL_W-1:0]      rd_data;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [VAL_W-1:0]      wr_data;

  logic                  out_free;
  logic                  issue;
  logic                  hit;
  logic                  miss;
  logic                  push;
  logic                  in_acc;
  logic                  list_last;

  ist_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (VAL_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;
  assign out_free   = !out_valid_r || out_tready;
  assign list_last  = (chk_idx_r == '0);

  // RAM access and step control
  always_comb begin
    issue   = 1'b0;
    miss    = 1'b0;
    push    = 1'b0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = value_r;
    rd_addr = addr_r[IDX_W-1:0];
    hit     = chk_valid_r && (rd_data == value_r);
    case (state_r)
      S_SCAN: begin
        issue = (addr_r < count_r) && !hit;
        miss  = !chk_valid_r && !issue;
        // append an absent value at the end of the packed run
        if (miss && (func_r == FN_INSERT) && (count_r < CNT_W'(CAPACITY))) begin
          wr_en   = 1'b1;
          wr_addr = count_r[IDX_W-1:0];
        end
      end
      S_SHIFT: begin
        issue = (addr_r < count_r);
        // move the entry read last cycle one place down
        if (chk_valid_r) begin
          wr_en   = 1'b1;
          wr_addr = chk_idx_r - IDX_W'(1);
          wr_data = rd_data;
        end
      end
      S_LIST: begin
        push  = chk_valid_r && out_free;
        issue = lst_more_r && (!chk_valid_r || push);
      end
      S_EMIT: begin
        push = out_free;
      end
      default: begin
        issue = 1'b0;
      end
    endcase
    rd_en = issue;
  end

  // Sequencer, count and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      chk_valid_r <= 1'b0;
      lst_more_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // output register handshake
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            func_r        <= in_tuser;
            value_r       <= in_tdata;
            chk_valid_r   <= 1'b0;
            res_found_r   <= 1'b0;
            res_refused_r <= 1'b0;
            case (in_tuser)
              FN_INSERT, FN_DELETE, FN_LOOKUP: begin
                addr_r  <= '0;
                state_r <= S_SCAN;
              end
              FN_LIST: begin
                if (count_r == '0) begin
                  state_r <= S_EMIT;
                end else begin
                  addr_r     <= count_r - CNT_W'(1);
                  lst_more_r <= 1'b1;
                  state_r    <= S_LIST;
                end
              end
              FN_CLEAR: begin
                count_r <= '0;
                state_r <= S_EMIT;
              end
              default: begin
                state_r <= S_EMIT;
              end
            endcase
          end
        end

        S_SCAN: begin
          // issue is low on a hit, so the check pipe drains by itself
          chk_valid_r <= issue;
          chk_idx_r   <= addr_r[IDX_W-1:0];
          if (issue) begin
            addr_r <= addr_r + CNT_W'(1);
          end
          if (hit) begin
            res_found_r <= 1'b1;
            if (func_r == FN_DELETE) begin
              addr_r  <= CNT_W'(chk_idx_r) + CNT_W'(1);
              state_r <= S_SHIFT;
            end else begin
              state_r <= S_EMIT;
            end
          end else if (miss) begin
            if (func_r == FN_INSERT) begin
              if (count_r < CNT_W'(CAPACITY)) begin
                count_r <= count_r + CNT_W'(1);
              end else begin
                res_refused_r <= 1'b1;
              end
            end
            state_r <= S_EMIT;
          end
        end

        S_SHIFT: begin
          chk_valid_r <= issue;
          chk_idx_r   <= addr_r[IDX_W-1:0];
          if (issue) begin
            addr_r <= addr_r + CNT_W'(1);
          end
          if (!chk_valid_r && !issue) begin
            count_r <= count_r - CNT_W'(1);
            state_r <= S_EMIT;
          end
        end

        S_LIST: begin
          chk_valid_r <= issue || (chk_valid_r && !push);
          if (issue) begin
            chk_idx_r <= addr_r[IDX_W-1:0];
            if (addr_r == '0) begin
              lst_more_r <= 1'b0;
            end else begin
              addr_r <= addr_r - CNT_W'(1);
            end
          end
          if (push) begin
            out_data_r <= {1'b0, rd_data, CNT_F_W'(count_r), 1'b0, 1'b0};
            out_user_r <= 1'b1;
            out_last_r <= list_last;
            if (list_last) begin
              state_r <= S_IDLE;
            end
          end
        end

        S_EMIT: begin
          if (push) begin
            out_data_r <= {1'b0, VAL_W'(0), CNT_F_W'(count_r), res_refused_r,
                           res_found_r};
            out_user_r <= 1'b0;
            out_last_r <= 1'b1;
            state_r    <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // the set never grows past the store
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("element count above capacity");

  // count moves by one step, or drops to zero on clear
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(count_r) |->
      (count_r == $past(count_r) + CNT_W'(1)) ||
      (count_r == $past(count_r) - CNT_W'(1)) || (count_r == '0))
    else $error("element count jumped");

  // no RAM write targets the entry being read
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("RAM read and write on one entry");

  // only list runs give results without last, and those carry an element
  a_run_elem: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> out_user_r)
    else $error("non-final result without element");

  // no new request is taken while a list run is under way
  a_list_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LIST) |-> !in_tready)
    else $error("request taken during list run");
`endif

endmodule

`default_nettype wire
